@@ src/scan_wall_segment_detector_top_defines.svh @@
// ---------------------------------------------------------------------------
// Scan wall segment detector assertion macros
// Shared property forms for the checker of the detector top level.
// ---------------------------------------------------------------------------
`ifndef SCAN_WALL_SEGMENT_DETECTOR_TOP_DEFINES_SVH
`define SCAN_WALL_SEGMENT_DETECTOR_TOP_DEFINES_SVH

// Same-cycle implication on the rising edge, off during reset
`define SWSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on the rising edge, off during reset
`define SWSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/swsd_pkg.sv @@
// ---------------------------------------------------------------------------
// Scan wall segment detector package
// Types, constants and tables shared by the detector modules.
// ---------------------------------------------------------------------------
package swsd_pkg;

    localparam int SCAN_POINTS = 1024;
    localparam int IDX_W       = $clog2(SCAN_POINTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int MIN_SEGMENT = 3;

    // Item queue between front and back
    localparam int IQ_DEPTH = 4;
    localparam int IQ_PTR_W = $clog2(IQ_DEPTH);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_ANGLE_START = 3'd1,
        CFG_ANGLE_STEP  = 3'd2,
        CFG_RANGE_LOWER = 3'd3,
        CFG_RANGE_UPPER = 3'd4,
        CFG_CONFIDENCE  = 3'd5,
        CFG_GAP_LIMIT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        enable;
        logic [15:0] angle_start;
        logic [15:0] angle_step;
        logic [15:0] range_lower;
        logic [15:0] range_upper;
        logic [16:0] confidence;
        logic [15:0] gap_limit;
    } t_cfg;

    // One sample after classification
    typedef struct packed {
        logic             kept;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic [15:0]      range;
        logic [15:0]      angle;
    } t_item;

    typedef struct packed {
        logic [9:0]  first_index;
        logic [9:0]  end_index;
        logic [10:0] point_count;
        logic        wall_found;
        logic        scan_done;
    } t_result;

    // CORDIC: Q16 inverse gain, arc table in 1/2^24 turn
    localparam logic [15:0] CORDIC_GAIN = 16'd39796;
    localparam int          CORDIC_STEPS = 16;
    localparam logic [21:0] ARC_TABLE [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050,
        22'd166669,  22'd83416,   22'd41718,  22'd20860,
        22'd10430,   22'd5215,    22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81
    };
    localparam int COORD_LIMIT = 65535;

    // Flatness limit: d * 10^6 < n * 2^20
    localparam logic [31:0] FLAT_SCALE = 32'd1000000;
    localparam int          FLAT_SHIFT = 20;
    localparam logic [16:0] CONF_ONE   = 17'd65536;

    // Digit-serial wide multiplier
    localparam int WM_A_W   = 128;
    localparam int WM_B_W   = 64;
    localparam int WM_DIG   = 4;
    localparam int WM_STEPS = WM_B_W / WM_DIG;
    localparam int WM_CNT_W = $clog2(WM_STEPS);

endpackage

@@ src/swsd_wmul.sv @@
// ---------------------------------------------------------------------------
// Wide digit-serial multiplier
// Unsigned A times B, one 4-bit digit of B per cycle, product truncated.
// ---------------------------------------------------------------------------
module swsd_wmul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [swsd_pkg::WM_A_W-1:0]  i_a,
    input  logic [swsd_pkg::WM_B_W-1:0]  i_b,
    output logic                         o_done,
    output logic [swsd_pkg::WM_A_W-1:0]  o_p
);
    import swsd_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [WM_CNT_W-1:0] r_cnt;
    logic [WM_A_W-1:0]   r_a;
    logic [WM_B_W-1:0]   r_b;
    logic [WM_A_W-1:0]   r_acc;

    // Load operands, then add one partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= r_acc + WM_A_W'(r_a * r_b[WM_DIG-1:0]);
                r_a   <= r_a << WM_DIG;
                r_b   <= r_b >> WM_DIG;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == WM_CNT_W'(WM_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

@@ src/swsd_iq.sv @@
// ---------------------------------------------------------------------------
// Item queue
// Short queue of classified samples between the front and the back.
// ---------------------------------------------------------------------------
module swsd_iq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  swsd_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_rd,
    output swsd_pkg::t_item o_item,
    output logic            o_empty
);
    import swsd_pkg::*;

    t_item               r_mem [IQ_DEPTH];
    logic [IQ_PTR_W-1:0] r_wp;
    logic [IQ_PTR_W-1:0] r_rp;
    logic [IQ_PTR_W:0]   r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_cnt == (IQ_PTR_W+1)'(IQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_item  = r_mem[r_rp];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ src/swsd_front.sv @@
// ---------------------------------------------------------------------------
// Sample front end
// Counts sample indices, windows the range and computes the sample angle.
// ---------------------------------------------------------------------------
module swsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  swsd_pkg::t_cfg  i_cfg,
    input  logic            i_take,
    input  logic [15:0]     i_range,
    input  logic            i_not_finite,
    input  logic            i_scan_end,
    output logic            o_wr,
    output swsd_pkg::t_item o_item
);
    import swsd_pkg::*;

    logic [IDX_W-1:0] r_idx;
    logic             last;
    logic [15:0]      ang_ofs;

    // Classify the incoming sample
    assign last    = i_scan_end || (r_idx == IDX_W'(SCAN_POINTS - 1));
    assign ang_ofs = 16'(r_idx * i_cfg.angle_step);

    assign o_wr         = i_take && i_cfg.enable;
    assign o_item.kept  = !i_not_finite && (i_range > i_cfg.range_lower)
                          && (i_range < i_cfg.range_upper);
    assign o_item.last  = last;
    assign o_item.idx   = r_idx;
    assign o_item.range = i_range;
    assign o_item.angle = i_cfg.angle_start + ang_ofs;

    // Advance the index, restart on the scan's last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_wr) begin
            r_idx <= last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

@@ src/swsd_back.sv @@
// ---------------------------------------------------------------------------
// Segment back end
// CORDIC conversion, gap test, running sums and the R squared wall test.
// ---------------------------------------------------------------------------
module swsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swsd_pkg::t_cfg    i_cfg,
    input  logic              i_iq_empty,
    input  swsd_pkg::t_item   i_iq_item,
    output logic              o_iq_pop,
    output logic              o_res_valid,
    output swsd_pkg::t_result o_res,
    input  logic              i_res_pop
);
    import swsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CINIT, S_CORD, S_CFIN, S_GAP, S_SQ,
        S_LASTCHK, S_TEST, S_CLEAR, S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        T_NSXX, T_SXSX, T_NSYY, T_SYSY, T_NSXY, T_SXSY,
        T_FLAT, T_DXY2, T_DXXDYY, T_CONF
    } t_tstep;

    t_state r_state;
    t_tstep r_tstep;
    t_item  r_item;
    logic   r_wall;
    logic   r_ret;
    logic   r_ext;
    logic   r_issued;
    logic [1:0] r_sub;

    logic signed [35:0] r_cx, r_cy;
    logic signed [25:0] r_cz;
    logic [3:0]         r_ci;
    logic signed [16:0] r_x, r_y, r_px, r_py;
    logic [36:0]        r_d2;
    logic signed [33:0] r_pxx, r_pyy, r_pxy;

    logic             r_open;
    logic [IDX_W-1:0] r_first, r_end, r_wf, r_we;
    logic [CNT_W-1:0] r_count, r_wc;
    logic signed [26:0] r_sx, r_sy;
    logic [42:0]        r_sxx, r_syy;
    logic signed [43:0] r_sxy;

    logic signed [63:0] r_p, r_dxx, r_dyy, r_dxy;
    logic [WM_A_W-1:0]  r_left, r_right;

    logic    r_out_valid;
    t_result r_out;

    // Flatness test on a centered second moment
    function automatic logic too_flat(input logic signed [63:0] d,
                                      input logic [CNT_W-1:0] n);
        logic [31:0] lhs;
        logic [31:0] rhs;
        logic        small_d;
        small_d = d[62:0] < 63'({n, 1'b0});
        lhs     = 32'(d[11:0]) * FLAT_SCALE;
        rhs     = 32'(n) << FLAT_SHIFT;
        return d[63] || (small_d && (lhs < rhs));
    endfunction

    // CORDIC start vector and step
    logic signed [25:0] z0;
    logic [31:0]        xr;
    logic signed [35:0] x0;
    logic signed [25:0] arc;
    logic signed [35:0] sh_x, sh_y;
    logic signed [35:0] rnd_x, rnd_y;
    logic signed [19:0] cx20, cy20;

    assign z0    = {{2{r_item.angle[15]}}, r_item.angle, 8'b0};
    assign xr    = 32'(r_item.range) * 32'(CORDIC_GAIN);
    assign x0    = {4'b0, xr};
    assign arc   = {4'b0, ARC_TABLE[r_ci]};
    assign sh_x  = r_cx >>> r_ci;
    assign sh_y  = r_cy >>> r_ci;
    assign rnd_x = (r_cx + 36'sd32768) >>> 16;
    assign rnd_y = (r_cy + 36'sd32768) >>> 16;
    assign cx20  = 20'(rnd_x);
    assign cy20  = 20'(rnd_y);

    function automatic logic signed [16:0] clamp17(input logic signed [19:0] v);
        if (v > 20'sd65535) begin
            return 17'sd65535;
        end else if (v < -20'sd65535) begin
            return -17'sd65535;
        end
        return 17'(v);
    endfunction

    // Shared narrow multiplier for gap and moment products
    logic signed [17:0] m_a, m_b;
    logic signed [35:0] m_p;
    logic signed [17:0] gap18;

    assign gap18 = {2'b0, i_cfg.gap_limit};

    always_comb begin
        m_a = 18'(r_x);
        m_b = 18'(r_x);
        if (r_state == S_GAP) begin
            case (r_sub)
                2'd0: begin
                    m_a = 18'(r_x) - 18'(r_px);
                    m_b = 18'(r_x) - 18'(r_px);
                end
                2'd1: begin
                    m_a = 18'(r_y) - 18'(r_py);
                    m_b = 18'(r_y) - 18'(r_py);
                end
                default: begin
                    m_a = gap18;
                    m_b = gap18;
                end
            endcase
        end else begin
            case (r_sub)
                2'd0:    m_b = 18'(r_x);
                2'd1: begin
                    m_a = 18'(r_y);
                    m_b = 18'(r_y);
                end
                default: m_b = 18'(r_y);
            endcase
        end
    end

    assign m_p = m_a * m_b;

    // Wide multiplier operand selection for the wall test
    logic signed [63:0] sx64, sy64, sxy64;
    logic [63:0]        ax, ay, axy, adxy;
    logic [WM_A_W-1:0]  wm_a;
    logic [WM_B_W-1:0]  wm_b;
    logic               wm_start, wm_done;
    logic [WM_A_W-1:0]  wm_p;
    logic signed [63:0] res64;

    assign sx64  = 64'(r_sx);
    assign sy64  = 64'(r_sy);
    assign sxy64 = 64'(r_sxy);
    assign ax    = sx64[63] ? 64'(-sx64) : 64'(sx64);
    assign ay    = sy64[63] ? 64'(-sy64) : 64'(sy64);
    assign axy   = sxy64[63] ? 64'(-sxy64) : 64'(sxy64);
    assign adxy  = r_dxy[63] ? 64'(-r_dxy) : 64'(r_dxy);
    assign res64 = 64'(wm_p);

    always_comb begin
        wm_a = '0;
        wm_b = '0;
        unique case (r_tstep)
            T_NSXX: begin
                wm_a = WM_A_W'(r_count);
                wm_b = 64'(r_sxx);
            end
            T_SXSX: begin
                wm_a = WM_A_W'(ax);
                wm_b = ax;
            end
            T_NSYY: begin
                wm_a = WM_A_W'(r_count);
                wm_b = 64'(r_syy);
            end
            T_SYSY: begin
                wm_a = WM_A_W'(ay);
                wm_b = ay;
            end
            T_NSXY: begin
                wm_a = WM_A_W'(r_count);
                wm_b = axy;
            end
            T_SXSY: begin
                wm_a = WM_A_W'(ax);
                wm_b = ay;
            end
            T_DXY2: begin
                wm_a = WM_A_W'(adxy);
                wm_b = adxy;
            end
            T_DXXDYY: begin
                wm_a = WM_A_W'(64'(r_dxx));
                wm_b = 64'(r_dyy);
            end
            T_CONF: begin
                wm_a = r_right;
                wm_b = 64'(i_cfg.confidence);
            end
            default: begin
                wm_a = '0;
                wm_b = '0;
            end
        endcase
    end

    assign wm_start = (r_state == S_TEST) && (r_tstep != T_FLAT) && !r_issued;

    swsd_wmul u_wmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wm_start),
        .i_a     (wm_a),
        .i_b     (wm_b),
        .o_done  (wm_done),
        .o_p     (wm_p)
    );

    // Wall test outcome
    logic flat_x, flat_y, t_fin, t_pass, big_seg;

    assign flat_x  = too_flat(r_dxx, r_count);
    assign flat_y  = too_flat(r_dyy, r_count);
    assign big_seg = r_count >= CNT_W'(MIN_SEGMENT);

    always_comb begin
        t_fin  = 1'b0;
        t_pass = 1'b0;
        if (r_state == S_TEST) begin
            if (r_tstep == T_FLAT) begin
                t_fin  = flat_x || flat_y;
                t_pass = flat_x ? (i_cfg.confidence == '0)
                                : (i_cfg.confidence <= CONF_ONE);
            end else if (r_tstep == T_CONF && r_issued && wm_done) begin
                t_fin  = 1'b1;
                t_pass = r_left >= wm_p;
            end
        end
    end

    // Load the output register this cycle
    logic emit_go;

    assign emit_go     = (r_state == S_EMIT) && (r_wall || r_item.last)
                         && (!r_out_valid || i_res_pop);
    assign o_iq_pop    = (r_state == S_IDLE) && !i_iq_empty;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Sequencer: state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tstep     <= T_NSXX;
            r_issued    <= 1'b0;
            r_open      <= 1'b0;
            r_count     <= '0;
            r_wall      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result once transferred
            if (i_res_pop && r_out_valid && !emit_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_iq_empty) begin
                        r_item  <= i_iq_item;
                        r_wall  <= 1'b0;
                        r_state <= i_iq_item.kept ? S_CINIT : S_LASTCHK;
                    end
                end
                S_CINIT: begin
                    r_cy <= '0;
                    r_ci <= '0;
                    if (z0 > 26'sd4194304) begin
                        r_cx <= -x0;
                        r_cz <= z0 - 26'sd8388608;
                    end else if (z0 < -26'sd4194304) begin
                        r_cx <= -x0;
                        r_cz <= z0 + 26'sd8388608;
                    end else begin
                        r_cx <= x0;
                        r_cz <= z0;
                    end
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_cz[25]) begin
                        r_cx <= r_cx - sh_y;
                        r_cy <= r_cy + sh_x;
                        r_cz <= r_cz - arc;
                    end else begin
                        r_cx <= r_cx + sh_y;
                        r_cy <= r_cy - sh_x;
                        r_cz <= r_cz + arc;
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == 4'(CORDIC_STEPS - 1)) begin
                        r_state <= S_CFIN;
                    end
                end
                S_CFIN: begin
                    r_x   <= clamp17(cx20);
                    r_y   <= clamp17(cy20);
                    r_sub <= '0;
                    r_ext <= 1'b0;
                    r_state <= r_open ? S_GAP : S_SQ;
                end
                S_GAP: begin
                    case (r_sub)
                        2'd0: begin
                            r_d2  <= {1'b0, 36'(m_p)};
                            r_sub <= r_sub + 1'b1;
                        end
                        2'd1: begin
                            r_d2  <= r_d2 + {1'b0, 36'(m_p)};
                            r_sub <= r_sub + 1'b1;
                        end
                        default: begin
                            r_sub <= '0;
                            if (r_d2 < {1'b0, 36'(m_p)}) begin
                                r_ext   <= 1'b1;
                                r_state <= S_SQ;
                            end else if (big_seg) begin
                                r_ret    <= 1'b1;
                                r_tstep  <= T_NSXX;
                                r_issued <= 1'b0;
                                r_state  <= S_TEST;
                            end else begin
                                r_state <= S_SQ;
                            end
                        end
                    endcase
                end
                S_SQ: begin
                    case (r_sub)
                        2'd0: begin
                            r_pxx <= 34'(m_p);
                            r_sub <= r_sub + 1'b1;
                        end
                        2'd1: begin
                            r_pyy <= 34'(m_p);
                            r_sub <= r_sub + 1'b1;
                        end
                        2'd2: begin
                            r_pxy <= 34'(m_p);
                            r_sub <= r_sub + 1'b1;
                        end
                        default: begin
                            r_sub <= '0;
                            r_px  <= r_x;
                            r_py  <= r_y;
                            r_end <= r_item.idx;
                            if (r_ext) begin
                                r_count <= r_count + 1'b1;
                                r_sx    <= r_sx + 27'(r_x);
                                r_sy    <= r_sy + 27'(r_y);
                                r_sxx   <= r_sxx + 43'(r_pxx);
                                r_syy   <= r_syy + 43'(r_pyy);
                                r_sxy   <= r_sxy + 44'(r_pxy);
                            end else begin
                                r_open  <= 1'b1;
                                r_first <= r_item.idx;
                                r_count <= CNT_W'(1);
                                r_sx    <= 27'(r_x);
                                r_sy    <= 27'(r_y);
                                r_sxx   <= 43'(r_pxx);
                                r_syy   <= 43'(r_pyy);
                                r_sxy   <= 44'(r_pxy);
                            end
                            r_state <= S_LASTCHK;
                        end
                    endcase
                end
                S_LASTCHK: begin
                    if (!r_item.last) begin
                        r_state <= S_EMIT;
                    end else if (r_open && big_seg) begin
                        r_ret    <= 1'b0;
                        r_tstep  <= T_NSXX;
                        r_issued <= 1'b0;
                        r_state  <= S_TEST;
                    end else begin
                        r_state <= S_CLEAR;
                    end
                end
                S_TEST: begin
                    if (t_fin) begin
                        r_wall   <= t_pass;
                        r_wf     <= r_first;
                        r_we     <= r_end;
                        r_wc     <= r_count;
                        r_issued <= 1'b0;
                        r_tstep  <= T_NSXX;
                        r_ext    <= 1'b0;
                        r_sub    <= '0;
                        r_state  <= r_ret ? S_SQ : S_CLEAR;
                    end else if (r_tstep == T_FLAT) begin
                        r_tstep <= T_DXY2;
                    end else if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (wm_done) begin
                        r_issued <= 1'b0;
                        r_tstep  <= t_tstep'(r_tstep + 1'b1);
                        case (r_tstep)
                            T_NSXX:   r_p    <= res64;
                            T_SXSX:   r_dxx  <= r_p - res64;
                            T_NSYY:   r_p    <= res64;
                            T_SYSY:   r_dyy  <= r_p - res64;
                            T_NSXY:   r_p    <= sxy64[63] ? -res64 : res64;
                            T_SXSY:   r_dxy  <= r_p - ((sx64[63] ^ sy64[63]) ? -res64
                                                                           : res64);
                            T_DXY2:   r_left <= wm_p << 16;
                            T_DXXDYY: r_right <= wm_p;
                            default:  r_p    <= r_p;
                        endcase
                    end
                end
                S_CLEAR: begin
                    r_open  <= 1'b0;
                    r_count <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_wall || r_item.last) begin
                        if (emit_go) begin
                            r_out_valid       <= 1'b1;
                            r_out.first_index <= r_wall ? 10'(r_wf) : '0;
                            r_out.end_index   <= r_wall ? 10'(r_we) : '0;
                            r_out.point_count <= r_wall ? 11'(r_wc) : '0;
                            r_out.wall_found  <= r_wall;
                            r_out.scan_done   <= r_item.last;
                            r_state           <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/scan_wall_segment_detector_top.sv @@
// ---------------------------------------------------------------------------
// Scan wall segment detector
// Finds straight wall segments in one lidar scan and reports their spans.
// ---------------------------------------------------------------------------
// Samples are taken one per cycle while the queue is not full, into a
// four-entry queue; the back end takes one sample at a time and pops the next
// only when done with it. A kept sample passes the iterative CORDIC, one
// stage per cycle, then a gap test if it follows an open segment. A closing
// segment of three or more points adds the wall test: up to nine 128-by-64
// products on the shared digit-serial multiplier and a flatness check that can
// end the test early. Results leave through a one-entry output register, so a
// stalled reader holds only the back end while the queue keeps filling.
module scan_wall_segment_detector_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swsd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic [15:0]                    i_range,
    input  logic                           i_not_finite,
    input  logic                           i_scan_end,
    output logic                           empty,
    input  logic                           pop,
    output logic [9:0]                     o_first_index,
    output logic [9:0]                     o_end_index,
    output logic [10:0]                    o_point_count,
    output logic                           o_wall_found,
    output logic                           o_scan_done
);
    import swsd_pkg::*;

    t_cfg    r_cfg;
    t_item   fe_item, iq_item;
    logic    fe_wr, iq_full, iq_empty, iq_pop;
    logic    res_valid;
    t_result res;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable      <= 1'b1;
            r_cfg.angle_start <= 16'h8000;
            r_cfg.angle_step  <= 16'd64;
            r_cfg.range_lower <= 16'd123;
            r_cfg.range_upper <= 16'd3072;
            r_cfg.confidence  <= 17'd52429;
            r_cfg.gap_limit   <= 16'd154;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ENABLE:      r_cfg.enable      <= i_cfg_data[0];
                CFG_ANGLE_START: r_cfg.angle_start <= i_cfg_data[15:0];
                CFG_ANGLE_STEP:  r_cfg.angle_step  <= i_cfg_data[15:0];
                CFG_RANGE_LOWER: r_cfg.range_lower <= i_cfg_data[15:0];
                CFG_RANGE_UPPER: r_cfg.range_upper <= i_cfg_data[15:0];
                CFG_CONFIDENCE:  r_cfg.confidence  <= i_cfg_data;
                CFG_GAP_LIMIT:   r_cfg.gap_limit   <= i_cfg_data[15:0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    assign full = iq_full;

    swsd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_take       (push && !iq_full),
        .i_range      (i_range),
        .i_not_finite (i_not_finite),
        .i_scan_end   (i_scan_end),
        .o_wr         (fe_wr),
        .o_item       (fe_item)
    );

    swsd_iq u_iq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fe_wr),
        .i_item  (fe_item),
        .o_full  (iq_full),
        .i_rd    (iq_pop),
        .o_item  (iq_item),
        .o_empty (iq_empty)
    );

    swsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_iq_empty  (iq_empty),
        .i_iq_item   (iq_item),
        .o_iq_pop    (iq_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    // Drive the result ports
    assign empty         = !res_valid;
    assign o_first_index = res.first_index;
    assign o_end_index   = res.end_index;
    assign o_point_count = res.point_count;
    assign o_wall_found  = res.wall_found;
    assign o_scan_done   = res.scan_done;

endmodule

@@ src/swsd_checker.sv @@
// ---------------------------------------------------------------------------
// Scan wall segment detector checker
// Port-level properties of the detector, bound to the top level.
// ---------------------------------------------------------------------------
`include "scan_wall_segment_detector_top_defines.svh"

module swsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [9:0]  o_first_index,
    input logic [9:0]  o_end_index,
    input logic [10:0] o_point_count,
    input logic        o_wall_found,
    input logic        o_scan_done
);

    // A reported wall has at least three points
    `SWSD_ASSERT_IMP(a_wall_min, !empty && o_wall_found, o_point_count >= 11'd3, "short wall")

    // A result without a wall closes the scan and carries no span
    `SWSD_ASSERT_IMP(a_nowall, !empty && !o_wall_found, o_scan_done && o_point_count == 11'd0 && o_first_index == 10'd0 && o_end_index == 10'd0, "bad empty result")

    // Points of a wall fit inside its index span
    `SWSD_ASSERT_IMP(a_span, !empty && o_wall_found, o_end_index >= o_first_index && (11'(o_end_index) - 11'(o_first_index) + 11'd1) >= o_point_count, "span too small")

    // A waiting result holds until transferred
    `SWSD_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(o_first_index) && $stable(o_point_count) && $stable(o_wall_found) && $stable(o_scan_done), "result changed")

endmodule

bind scan_wall_segment_detector_top swsd_checker u_swsd_checker (.*);
